### rtl/adv_data_structure_router_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the advertising data structure router
// Concurrent checks sampled on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ADV_DATA_STRUCTURE_ROUTER_CORE_DEFINES_SVH
`define ADV_DATA_STRUCTURE_ROUTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ADSR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ADSR_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define ADSR_ASSERT(label, prop, msg)
`define ADSR_ASSERT_NEVER(label, expr, msg)
`endif

`endif

### rtl/adsr_pkg.sv
// ---------------------------------------------------------------------------
// adsr_pkg
// Types and codes shared by the advertising data structure router.
// ---------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

   localparam logic [3:0] NONCONN_KIND = 4'd3;

   localparam logic [7:0] TYPE_PROV   = 8'h29;
   localparam logic [7:0] TYPE_MESH   = 8'h2A;
   localparam logic [7:0] TYPE_BEACON = 8'h2B;
   localparam logic [7:0] TYPE_MANUF  = 8'hFF;

   localparam logic [1:0] DEST_NET    = 2'd0;
   localparam logic [1:0] DEST_PROV   = 2'd1;
   localparam logic [1:0] DEST_BEACON = 2'd2;
   localparam logic [1:0] DEST_VENDOR = 2'd3;

   localparam logic [1:0] STATUS_PAYLOAD    = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED  = 2'd1;
   localparam logic [1:0] STATUS_TERMINATED = 2'd2;

   localparam logic REG_PROV_ENABLE   = 1'b0;
   localparam logic REG_VENDOR_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      PH_LEN   = 2'd0,
      PH_TYPE  = 2'd1,
      PH_MORE  = 2'd2,
      PH_FIRST = 2'd3
   } phase_type;

   typedef struct packed {
      logic              prov_enable;
      logic              vendor_enable;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic              report_start;
      logic [4:0]        report_length;
      logic [3:0]        pdu_kind;
      logic signed [7:0] signal_strength;
      logic [47:0]       source_address;
   } req_type;

   typedef struct packed {
      logic [1:0]        destination;
      logic [7:0]        payload_byte;
      logic              record_start;
      logic              record_last;
      logic              record_empty;
      logic [1:0]        status;
      logic signed [7:0] record_rssi;
      logic [47:0]       record_address;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/adv_data_structure_router_core.sv
// ---------------------------------------------------------------------------
// adv_data_structure_router_core
// Parses received advertising reports byte by byte and routes the payload of
// mesh, provisioning, beacon and manufacturer data structures.
// A record appears on the rsp channel in the cycle after its transaction is accepted.
// Throughput: one byte per cycle unless the result register is full and held.
// Reset: synchronous; parser returns to length-byte phase, prov_enable set,
// vendor_enable clear, result register empty.
// ---------------------------------------------------------------------------
`default_nettype none

module adv_data_structure_router_core #(
   parameter int MAX_REPORT_BYTES = 31
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire [7:0]         req_data_byte,
   input  wire               req_report_start,
   input  wire [4:0]         req_report_length,
   input  wire [3:0]         req_pdu_kind,
   input  wire signed [7:0]  req_signal_strength,
   input  wire [47:0]        req_source_address,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic [1:0]        rsp_destination,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_record_start,
   output logic              rsp_record_last,
   output logic              rsp_record_empty,
   output logic [1:0]        rsp_status,
   output logic signed [7:0] rsp_record_rssi,
   output logic [47:0]       rsp_record_address,
   input  wire               csr_wr_en,
   input  wire               csr_index,
   input  wire               csr_wr_data
);
   import adsr_pkg::*;

   cfg_type cfg_ff;
   req_type item;
   rsp_type res, rsp_data;
   logic    res_valid, advance, slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prov_enable   <= 1'b1;
         cfg_ff.vendor_enable <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PROV_ENABLE:   cfg_ff.prov_enable   <= csr_wr_data;
            REG_VENDOR_ENABLE: cfg_ff.vendor_enable <= csr_wr_data;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign item.data_byte       = req_data_byte;
   assign item.report_start    = req_report_start;
   assign item.report_length   = req_report_length;
   assign item.pdu_kind        = req_pdu_kind;
   assign item.signal_strength = req_signal_strength;
   assign item.source_address  = req_source_address;

   assign req_ready = slot_free;
   assign advance   = req_valid && slot_free;

   adsr_parser #(
      .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   adsr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .load_data (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .slot_free (slot_free),
      .rsp_data  (rsp_data)
   );

   assign rsp_destination    = rsp_data.destination;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_record_start   = rsp_data.record_start;
   assign rsp_record_last    = rsp_data.record_last;
   assign rsp_record_empty   = rsp_data.record_empty;
   assign rsp_status         = rsp_data.status;
   assign rsp_record_rssi    = rsp_data.record_rssi;
   assign rsp_record_address = rsp_data.record_address;

endmodule

`default_nettype wire

### rtl/adsr_parser.sv
// ---------------------------------------------------------------------------
// adsr_parser
// Length-type-value walker: holds report and structure state, decodes one
// byte per transaction and forms the routed record or the status record.
// ---------------------------------------------------------------------------
`default_nettype none
`include "adv_data_structure_router_core_defines.svh"

module adsr_parser #(
   parameter int MAX_REPORT_BYTES = 31
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  adsr_pkg::req_type item,
   input  adsr_pkg::cfg_type cfg,
   output logic              res_valid,
   output adsr_pkg::rsp_type res
);
   import adsr_pkg::*;

   localparam int CAP    = (MAX_REPORT_BYTES < 31) ? MAX_REPORT_BYTES : 31;
   localparam int LEFT_W = $clog2(CAP + 1);

   phase_type         phase_ff, phase_in;
   logic [LEFT_W-1:0] rpt_left_ff, rpt_left_in;
   logic [LEFT_W-1:0] str_left_ff, str_left_in;
   logic [1:0]        dest_ff, dest_in;
   logic              str_acc_ff, str_acc_in;
   logic              rpt_acc_ff, rpt_acc_in;
   logic signed [7:0] rssi_ff, rssi_in;
   logic [47:0]       addr_ff, addr_in;

   phase_type         eff_phase;
   logic [LEFT_W-1:0] eff_left, eff_str_left, left_m1, str_dec;
   logic [1:0]        eff_dest, type_dest;
   logic              eff_str_acc, eff_rpt_acc, type_hit;
   logic              len_zero, len_over;

   always_comb begin
      if (item.report_start) begin
         if (int'(item.report_length) > CAP) begin
            eff_left = LEFT_W'(CAP);
         end else begin
            eff_left = LEFT_W'(item.report_length);
         end
         eff_rpt_acc  = (item.pdu_kind == NONCONN_KIND);
         eff_phase    = PH_LEN;
         eff_str_left = '0;
         eff_str_acc  = 1'b0;
         eff_dest     = DEST_NET;
         rssi_in      = item.signal_strength;
         addr_in      = item.source_address;
      end else begin
         eff_left     = rpt_left_ff;
         eff_rpt_acc  = rpt_acc_ff;
         eff_phase    = phase_ff;
         eff_str_left = str_left_ff;
         eff_str_acc  = str_acc_ff;
         eff_dest     = dest_ff;
         rssi_in      = rssi_ff;
         addr_in      = addr_ff;
      end
   end

   assign left_m1  = eff_left - LEFT_W'(1);
   assign str_dec  = (eff_str_left != '0) ? (eff_str_left - LEFT_W'(1)) : eff_str_left;
   assign len_zero = (item.data_byte == 8'd0);
   assign len_over = (item.data_byte > 8'(left_m1));

   always_comb begin
      case (item.data_byte)
         TYPE_MESH: begin
            type_dest = DEST_NET;
            type_hit  = 1'b1;
         end
         TYPE_PROV: begin
            type_dest = DEST_PROV;
            type_hit  = cfg.prov_enable;
         end
         TYPE_BEACON: begin
            type_dest = DEST_BEACON;
            type_hit  = 1'b1;
         end
         TYPE_MANUF: begin
            type_dest = DEST_VENDOR;
            type_hit  = cfg.vendor_enable;
         end
         default: begin
            type_dest = DEST_NET;
            type_hit  = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in    = eff_phase;
      rpt_left_in = eff_left;
      str_left_in = eff_str_left;
      dest_in     = eff_dest;
      str_acc_in  = eff_str_acc;
      rpt_acc_in  = eff_rpt_acc;
      if (eff_left == '0) begin
         phase_in = PH_LEN;
      end else begin
         rpt_left_in = left_m1;
         case (eff_phase)
            PH_LEN: begin
               if (eff_left > LEFT_W'(1)) begin
                  if (len_zero || len_over) begin
                     rpt_left_in = '0;
                  end else begin
                     str_left_in = LEFT_W'(item.data_byte - 8'd1);
                     phase_in    = PH_TYPE;
                  end
               end
            end
            PH_TYPE: begin
               dest_in    = type_dest;
               str_acc_in = type_hit && eff_rpt_acc;
               phase_in   = (eff_str_left == '0) ? PH_LEN : PH_FIRST;
            end
            PH_MORE, PH_FIRST: begin
               str_left_in = str_dec;
               phase_in    = (str_dec == '0) ? PH_LEN : PH_MORE;
            end
            default: begin
               phase_in = PH_LEN;
            end
         endcase
      end
   end

   // result
   always_comb begin
      res_valid          = 1'b0;
      res.destination    = DEST_NET;
      res.payload_byte   = 8'd0;
      res.record_start   = 1'b0;
      res.record_last    = 1'b0;
      res.record_empty   = 1'b0;
      res.status         = STATUS_PAYLOAD;
      res.record_rssi    = rssi_in;
      res.record_address = addr_in;
      if (eff_left != '0) begin
         case (eff_phase)
            PH_LEN: begin
               if (eff_left > LEFT_W'(1)) begin
                  if (len_zero) begin
                     res_valid  = eff_rpt_acc;
                     res.status = STATUS_TERMINATED;
                  end else if (len_over) begin
                     res_valid  = eff_rpt_acc;
                     res.status = STATUS_MALFORMED;
                  end
               end
            end
            PH_TYPE: begin
               if (eff_str_left == '0) begin
                  res_valid        = type_hit && eff_rpt_acc;
                  res.destination  = type_dest;
                  res.record_start = 1'b1;
                  res.record_last  = 1'b1;
                  res.record_empty = 1'b1;
               end
            end
            PH_MORE, PH_FIRST: begin
               res_valid        = eff_str_acc;
               res.destination  = eff_dest;
               res.payload_byte = item.data_byte;
               res.record_start = (eff_phase == PH_FIRST);
               res.record_last  = (str_dec == '0);
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN;
         rpt_left_ff <= '0;
         str_left_ff <= '0;
         dest_ff     <= DEST_NET;
         str_acc_ff  <= 1'b0;
         rpt_acc_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         rpt_left_ff <= rpt_left_in;
         str_left_ff <= str_left_in;
         dest_ff     <= dest_in;
         str_acc_ff  <= str_acc_in;
         rpt_acc_ff  <= rpt_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rssi_ff <= rssi_in;
         addr_ff <= addr_in;
      end
   end

   `ADSR_ASSERT(a_left_cap, (rpt_left_ff <= LEFT_W'(CAP)), "report count above cap")
   `ADSR_ASSERT(a_str_in_rpt, (phase_ff != PH_LEN) |-> (str_left_ff <= rpt_left_ff), "structure runs past report")
   `ADSR_ASSERT(a_res_acc, (advance && res_valid) |=> rpt_acc_ff, "record from unaccepted report")

endmodule

`default_nettype wire

### rtl/adsr_out_stage.sv
// ---------------------------------------------------------------------------
// adsr_out_stage
// Result register: holds one record until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "adv_data_structure_router_core_defines.svh"

module adsr_out_stage (
   input  wire               clock,
   input  wire               reset,
   input  wire               load,
   input  adsr_pkg::rsp_type load_data,
   input  wire               rsp_ready,
   output logic              rsp_valid,
   output logic              slot_free,
   output adsr_pkg::rsp_type rsp_data
);
   import adsr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `ADSR_ASSERT_NEVER(a_no_overwrite, load && valid_ff && !rsp_ready, "record overwritten")
   `ADSR_ASSERT(a_drain, (valid_ff && rsp_ready && !load) |=> !valid_ff, "record repeated")
   `ADSR_ASSERT(a_hold, (valid_ff && !rsp_ready) |=> (valid_ff && $stable(data_ff)), "record lost")

endmodule

`default_nettype wire
